### hw/rtl/assert_macros.svh
// Assertion helpers for the converter checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/biff8_pkg.sv
package biff8_pkg;

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_FLAGS,
      PH_RICH,
      PH_EXT,
      PH_CHARS,
      PH_SKIP
   } phase_type;

   typedef enum logic [2:0] {
      KIND_TEXT         = 3'd0,
      KIND_DONE         = 3'd1,
      KIND_SHORT_HEADER = 3'd2,
      KIND_SHORT_RICH   = 3'd3,
      KIND_SHORT_EXT    = 3'd4,
      KIND_SHORT_CHARS  = 3'd5,
      KIND_OVERRUN      = 3'd6
   } kind_type;

   localparam int unsigned TOTAL_W = 33;

   typedef struct packed {
      logic [2:0][7:0]      text;
      logic [1:0]           ntext;
      logic                 term;
      kind_type             kind;
      logic [TOTAL_W-1:0]   consumed;
   } bundle_type;

endpackage

### hw/rtl/biff8_parse.sv
module biff8_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  count_one,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output logic                  has_results,
   output biff8_pkg::bundle_type bundle
);

   biff8_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [15:0] chars_ff, chars_in;
   logic        comp_ff, comp_in;
   logic        hext_ff, hext_in;
   logic [15:0] rcnt_ff, rcnt_in;
   logic [31:0] esz_ff, esz_in;
   logic [7:0]  low_ff, low_in;
   logic [biff8_pkg::TOTAL_W-1:0] skip_ff, skip_in;
   logic [biff8_pkg::TOTAL_W-1:0] tot_ff, tot_in;

   logic        go_body, go_skip, done, emit;
   logic [15:0] cp;

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      chars_in = chars_ff;
      comp_in  = comp_ff;
      hext_in  = hext_ff;
      rcnt_in  = rcnt_ff;
      esz_in   = esz_ff;
      low_in   = low_ff;
      skip_in  = skip_ff;
      tot_in   = tot_ff + 33'd1;
      go_body  = 1'b0;
      go_skip  = 1'b0;
      done     = 1'b0;
      emit     = 1'b0;
      cp       = 16'd0;
      bundle   = '0;

      case (phase_ff)
         biff8_pkg::PH_COUNT: begin
            if (idx_ff == 2'd0) begin
               chars_in = {8'd0, in_byte};
               if (count_one) begin
                  phase_in = biff8_pkg::PH_FLAGS;
               end else begin
                  idx_in = 2'd1;
               end
            end else begin
               chars_in = {in_byte, chars_ff[7:0]};
               idx_in   = 2'd0;
               phase_in = biff8_pkg::PH_FLAGS;
            end
         end
         biff8_pkg::PH_FLAGS: begin
            comp_in = ~in_byte[0];
            hext_in = in_byte[2];
            rcnt_in = 16'd0;
            esz_in  = 32'd0;
            idx_in  = 2'd0;
            if (in_byte[3]) begin
               phase_in = biff8_pkg::PH_RICH;
            end else if (in_byte[2]) begin
               phase_in = biff8_pkg::PH_EXT;
            end else begin
               go_body = 1'b1;
            end
         end
         biff8_pkg::PH_RICH: begin
            if (idx_ff == 2'd0) begin
               rcnt_in = {8'd0, in_byte};
               idx_in  = 2'd1;
            end else begin
               rcnt_in = {in_byte, rcnt_ff[7:0]};
               idx_in  = 2'd0;
               if (hext_ff) begin
                  phase_in = biff8_pkg::PH_EXT;
               end else begin
                  go_body = 1'b1;
               end
            end
         end
         biff8_pkg::PH_EXT: begin
            case (idx_ff)
               2'd0:    esz_in = {esz_ff[31:8], in_byte};
               2'd1:    esz_in = {esz_ff[31:16], in_byte, esz_ff[7:0]};
               2'd2:    esz_in = {esz_ff[31:24], in_byte, esz_ff[15:0]};
               default: esz_in = {in_byte, esz_ff[23:0]};
            endcase
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               go_body = 1'b1;
            end
         end
         biff8_pkg::PH_CHARS: begin
            if (comp_ff) begin
               emit = 1'b1;
               cp   = {8'd0, in_byte};
            end else if (idx_ff == 2'd0) begin
               low_in = in_byte;
               idx_in = 2'd1;
            end else begin
               idx_in = 2'd0;
               emit   = 1'b1;
               cp     = {in_byte, low_ff};
            end
            if (emit) begin
               chars_in = chars_ff - 16'd1;
               if (chars_ff == 16'd1) begin
                  go_skip = 1'b1;
               end
            end
         end
         biff8_pkg::PH_SKIP: begin
            skip_in = skip_ff - 33'd1;
            if (skip_ff == 33'd1) begin
               done = 1'b1;
            end
         end
         default: begin
            phase_in = biff8_pkg::PH_COUNT;
         end
      endcase

      if (go_body) begin
         idx_in = 2'd0;
         if (chars_in != 16'd0) begin
            phase_in = biff8_pkg::PH_CHARS;
         end else begin
            go_skip = 1'b1;
         end
      end

      if (go_skip) begin
         skip_in = {15'd0, rcnt_in, 2'b00} + {1'b0, esz_in};
         if (skip_in == 33'd0) begin
            done = 1'b1;
         end else begin
            phase_in = biff8_pkg::PH_SKIP;
         end
      end

      if (emit) begin
         if (cp < 16'h0080) begin
            bundle.ntext   = 2'd1;
            bundle.text[0] = cp[7:0];
         end else if (cp < 16'h0800) begin
            bundle.ntext   = 2'd2;
            bundle.text[0] = {3'b110, cp[10:6]};
            bundle.text[1] = {2'b10, cp[5:0]};
         end else begin
            bundle.ntext   = 2'd3;
            bundle.text[0] = {4'b1110, cp[15:12]};
            bundle.text[1] = {2'b10, cp[11:6]};
            bundle.text[2] = {2'b10, cp[5:0]};
         end
      end

      if (done || in_last) begin
         bundle.term = 1'b1;
         if (done) begin
            bundle.kind     = biff8_pkg::KIND_DONE;
            bundle.consumed = tot_in;
         end else begin
            case (phase_in)
               biff8_pkg::PH_RICH:  bundle.kind = biff8_pkg::KIND_SHORT_RICH;
               biff8_pkg::PH_EXT:   bundle.kind = biff8_pkg::KIND_SHORT_EXT;
               biff8_pkg::PH_CHARS: bundle.kind = biff8_pkg::KIND_SHORT_CHARS;
               biff8_pkg::PH_SKIP:  bundle.kind = biff8_pkg::KIND_OVERRUN;
               default:             bundle.kind = biff8_pkg::KIND_SHORT_HEADER;
            endcase
         end
         phase_in = biff8_pkg::PH_COUNT;
         idx_in   = 2'd0;
         chars_in = 16'd0;
         comp_in  = 1'b0;
         hext_in  = 1'b0;
         rcnt_in  = 16'd0;
         esz_in   = 32'd0;
         low_in   = 8'd0;
         skip_in  = 33'd0;
         tot_in   = 33'd0;
      end

      has_results = emit | bundle.term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= biff8_pkg::PH_COUNT;
         idx_ff   <= 2'd0;
         chars_ff <= 16'd0;
         comp_ff  <= 1'b0;
         hext_ff  <= 1'b0;
         rcnt_ff  <= 16'd0;
         esz_ff   <= 32'd0;
         low_ff   <= 8'd0;
         skip_ff  <= 33'd0;
         tot_ff   <= 33'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         chars_ff <= chars_in;
         comp_ff  <= comp_in;
         hext_ff  <= hext_in;
         rcnt_ff  <= rcnt_in;
         esz_ff   <= esz_in;
         low_ff   <= low_in;
         skip_ff  <= skip_in;
         tot_ff   <= tot_in;
      end
   end

endmodule

### hw/rtl/biff8_emit.sv
module biff8_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  biff8_pkg::bundle_type         bundle,
   output logic                          free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_kind,
   output logic [7:0]                    rsp_byte,
   output logic [biff8_pkg::TOTAL_W-1:0] rsp_consumed,
   output logic                          rsp_last
);

   biff8_pkg::bundle_type bund_ff;
   logic       valid_ff;
   logic [1:0] pos_ff, pos_in;
   logic [2:0] count;
   logic       is_text, take;

   always_comb begin
      count   = {1'b0, bund_ff.ntext} + {2'b00, bund_ff.term};
      is_text = pos_ff < bund_ff.ntext;
      rsp_last = ({1'b0, pos_ff} + 3'd1) == count;
      rsp_valid = valid_ff;
      take    = valid_ff & rsp_ready;
      free    = ~valid_ff | (rsp_ready & rsp_last);
      pos_in  = pos_ff + 2'd1;
      if (is_text) begin
         rsp_kind     = biff8_pkg::KIND_TEXT;
         rsp_consumed = '0;
         case (pos_ff)
            2'd0:    rsp_byte = bund_ff.text[0];
            2'd1:    rsp_byte = bund_ff.text[1];
            2'd2:    rsp_byte = bund_ff.text[2];
            default: rsp_byte = 8'd0;
         endcase
      end else begin
         rsp_kind     = bund_ff.kind;
         rsp_consumed = bund_ff.consumed;
         rsp_byte     = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         pos_ff   <= 2'd0;
      end else if (take) begin
         if (rsp_last) begin
            valid_ff <= 1'b0;
         end
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bund_ff <= bundle;
      end
   end

endmodule

### hw/rtl/biff8_string_to_utf8_core.sv
// Channel   Ports                        Carries
// req       req_valid/req_ready          one raw byte and its end-of-buffer mark
// rsp       rsp_valid/rsp_ready          one UTF-8 byte, done count or truncation code
// csr       csr_write_enable/csr_wdata   count width select, no handshake
// A request is latched, then decoded combinationally into up to four results.
// A request that yields results loads them into the result register; one with
// none skips it. The result register drains one per cycle while rsp_ready is high.
// Reset (synchronous, active high) clears the string state and all valids.
// A stalled rsp side holds the results; the input register keeps accepting
// until a request with results waits behind them.
module biff8_string_to_utf8_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_byte,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_kind,
   output logic [7:0]                    rsp_byte,
   output logic [biff8_pkg::TOTAL_W-1:0] rsp_consumed,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic                          csr_wdata
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       count_one_ff;
   logic       has_results, free, fire;
   biff8_pkg::bundle_type bundle;

   assign fire      = in_valid_ff & (~has_results | free);
   assign req_ready = ~in_valid_ff | fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         count_one_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            count_one_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte;
         in_last_ff <= req_last;
      end
   end

   biff8_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (fire),
      .count_one   (count_one_ff),
      .in_byte     (in_byte_ff),
      .in_last     (in_last_ff),
      .has_results (has_results),
      .bundle      (bundle)
   );

   biff8_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (fire & has_results),
      .bundle       (bundle),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_byte     (rsp_byte),
      .rsp_consumed (rsp_consumed),
      .rsp_last     (rsp_last)
   );

endmodule

### hw/rtl/biff8_checker.sv
`include "assert_macros.svh"

module biff8_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_kind,
   input logic [7:0]                    rsp_byte,
   input logic [biff8_pkg::TOTAL_W-1:0] rsp_consumed,
   input logic                          rsp_last
);

   logic                            rsp_text, rsp_term;
   logic [biff8_pkg::TOTAL_W+11:0]  rsp_payload;

   assign rsp_text    = rsp_valid && (rsp_kind == biff8_pkg::KIND_TEXT);
   assign rsp_term    = rsp_valid && (rsp_kind != biff8_pkg::KIND_TEXT);
   assign rsp_payload = {rsp_kind, rsp_byte, rsp_consumed, rsp_last};

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
   `ASSERT_IMPLY(a_term_last, clock, reset, rsp_term, rsp_last)
   `ASSERT_IMPLY(a_text_no_count, clock, reset, rsp_text, rsp_consumed == '0)
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind biff8_string_to_utf8_core biff8_checker u_biff8_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_kind     (rsp_kind),
   .rsp_byte     (rsp_byte),
   .rsp_consumed (rsp_consumed),
   .rsp_last     (rsp_last)
);

### bench/biff8_utf8_checker.sv
`timescale 1ns / 1ps

module biff8_utf8_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [7:0]                    req_byte,
   input  logic                          req_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [2:0]                    rsp_kind,
   input  logic [7:0]                    rsp_byte,
   input  logic [biff8_pkg::TOTAL_W-1:0] rsp_consumed,
   input  logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic                          csr_wdata,
   output int                            failures,
   output int                            pending
);

   typedef struct packed {
      biff8_pkg::kind_type             kind;
      logic [7:0]                      data;
      logic [biff8_pkg::TOTAL_W-1:0]   consumed;
      logic                            last;
   } utf8_result_type;

   utf8_result_type expected_results[$];
   int mismatch_count = 0;

   bit                             count_one;
   biff8_pkg::phase_type           str_phase;
   logic [2:0]                     field_idx;
   logic [15:0]                    chars_left;
   bit                             narrow_chars;
   bit                             has_runs;
   bit                             has_ext;
   logic [15:0]                    run_count;
   logic [31:0]                    ext_size;
   logic [7:0]                     low_byte;
   logic [biff8_pkg::TOTAL_W-1:0]  skip_left;
   logic [biff8_pkg::TOTAL_W-1:0]  byte_total;
   bit                             string_done;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_string();
      str_phase = biff8_pkg::PH_COUNT;
      field_idx = '0;
      chars_left = '0;
      narrow_chars = 1'b0;
      has_runs = 1'b0;
      has_ext = 1'b0;
      run_count = '0;
      ext_size = '0;
      low_byte = '0;
      skip_left = '0;
      byte_total = '0;
   endtask

   task automatic push_result(input biff8_pkg::kind_type k, input logic [7:0] d,
                              input logic [biff8_pkg::TOTAL_W-1:0] c);
      utf8_result_type item;
      item.kind = k;
      item.data = d;
      item.consumed = c;
      item.last = 1'b0;
      expected_results.insert(expected_results.size(), item);
   endtask

   task automatic enter_skip();
      skip_left = {15'd0, run_count, 2'b00} + {1'b0, ext_size};
      if (skip_left != '0) str_phase = biff8_pkg::PH_SKIP;
      else string_done = 1'b1;
   endtask

   task automatic enter_body();
      field_idx = '0;
      if (chars_left != '0) str_phase = biff8_pkg::PH_CHARS;
      else enter_skip();
   endtask

   task automatic after_rich();
      field_idx = '0;
      if (has_ext) str_phase = biff8_pkg::PH_EXT;
      else enter_body();
   endtask

   task automatic emit_utf8(input logic [15:0] cp);
      if (cp < 16'h0080) begin
         push_result(biff8_pkg::KIND_TEXT, cp[7:0], '0);
      end else if (cp < 16'h0800) begin
         push_result(biff8_pkg::KIND_TEXT, {3'b110, cp[10:6]}, '0);
         push_result(biff8_pkg::KIND_TEXT, {2'b10, cp[5:0]}, '0);
      end else begin
         push_result(biff8_pkg::KIND_TEXT, {4'b1110, cp[15:12]}, '0);
         push_result(biff8_pkg::KIND_TEXT, {2'b10, cp[11:6]}, '0);
         push_result(biff8_pkg::KIND_TEXT, {2'b10, cp[5:0]}, '0);
      end
   endtask

   task automatic char_done();
      chars_left = chars_left - 16'd1;
      if (chars_left == '0) enter_skip();
   endtask

   task automatic predict_request(input logic [7:0] b, input logic last);
      int queued;
      biff8_pkg::kind_type code;
      utf8_result_type tail;
      queued = expected_results.size();
      byte_total = byte_total + 1'b1;
      string_done = 1'b0;
      case (str_phase)
         biff8_pkg::PH_COUNT: begin
            if (field_idx == '0) begin
               chars_left = {8'h00, b};
               if (count_one) str_phase = biff8_pkg::PH_FLAGS;
               else field_idx = 3'd1;
            end else begin
               chars_left[15:8] = b;
               field_idx = '0;
               str_phase = biff8_pkg::PH_FLAGS;
            end
         end
         biff8_pkg::PH_FLAGS: begin
            narrow_chars = !b[0];
            has_runs = b[3];
            has_ext = b[2];
            run_count = '0;
            ext_size = '0;
            field_idx = '0;
            if (has_runs) str_phase = biff8_pkg::PH_RICH;
            else after_rich();
         end
         biff8_pkg::PH_RICH: begin
            if (field_idx == '0) begin
               run_count = {8'h00, b};
               field_idx = 3'd1;
            end else begin
               run_count[15:8] = b;
               after_rich();
            end
         end
         biff8_pkg::PH_EXT: begin
            ext_size = ext_size | (32'(b) << (8 * field_idx[1:0]));
            field_idx = field_idx + 3'd1;
            if (field_idx >= 3'd4) enter_body();
         end
         biff8_pkg::PH_CHARS: begin
            if (narrow_chars) begin
               emit_utf8({8'h00, b});
               char_done();
            end else if (field_idx == '0) begin
               low_byte = b;
               field_idx = 3'd1;
            end else begin
               field_idx = '0;
               emit_utf8({b, low_byte});
               char_done();
            end
         end
         biff8_pkg::PH_SKIP: begin
            skip_left = skip_left - 1'b1;
            if (skip_left == '0) string_done = 1'b1;
         end
         default: clear_string();
      endcase

      if (string_done) begin
         push_result(biff8_pkg::KIND_DONE, '0, byte_total);
         clear_string();
      end else if (last) begin
         case (str_phase)
            biff8_pkg::PH_RICH:  code = biff8_pkg::KIND_SHORT_RICH;
            biff8_pkg::PH_EXT:   code = biff8_pkg::KIND_SHORT_EXT;
            biff8_pkg::PH_CHARS: code = biff8_pkg::KIND_SHORT_CHARS;
            biff8_pkg::PH_SKIP:  code = biff8_pkg::KIND_OVERRUN;
            default:             code = biff8_pkg::KIND_SHORT_HEADER;
         endcase
         push_result(code, '0, '0);
         clear_string();
      end

      if (expected_results.size() > queued) begin
         tail = expected_results[expected_results.size() - 1];
         tail.last = 1'b1;
         expected_results[expected_results.size() - 1] = tail;
      end
   endtask

   task automatic check_response();
      utf8_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing expected", longint'(rsp_kind), 0);
      end else begin
         want = expected_results.pop_front();
         if (rsp_kind !== want.kind)
            report_mismatch("kind", longint'(rsp_kind), longint'(want.kind));
         if (rsp_byte !== want.data)
            report_mismatch("byte", longint'(rsp_byte), longint'(want.data));
         if (rsp_consumed !== want.consumed)
            report_mismatch("consumed", longint'(rsp_consumed), longint'(want.consumed));
         if (rsp_last !== want.last)
            report_mismatch("last", longint'(rsp_last), longint'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         count_one = 1'b0;
         clear_string();
         expected_results.delete();
      end else begin
         if (csr_write_enable) count_one = csr_wdata;
         if (req_valid && req_ready) predict_request(req_byte, req_last);
         if (rsp_valid && rsp_ready) check_response();
      end
      pending <= expected_results.size();
      failures <= mismatch_count;
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_byte = 8'h00;
   logic                           req_last = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [2:0]                     rsp_kind;
   logic [7:0]                     rsp_byte;
   logic [biff8_pkg::TOTAL_W-1:0]  rsp_consumed;
   logic                           rsp_last;
   logic                           csr_write_enable = 1'b0;
   logic                           csr_wdata = 1'b0;

   int failures;
   int pending;

   int req_idle_pct = 29;
   int rsp_idle_pct = 81;
   int stall_id = 0;
   int stall_seen = 0;
   int hold_left = 0;
   int phase_bytes = 0;
   bit count_one = 1'b0;

   // {last, byte}
   logic [8:0] directed_seq [0:27] = '{
      9'h000, 9'h000, 9'h000,
      9'h003, 9'h000, 9'h001, 9'h07F, 9'h000, 9'h0FF, 9'h007, 9'h0FF, 9'h1FF,
      9'h000, 9'h000, 9'h004, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h1FF,
      9'h001, 9'h000, 9'h008, 9'h101,
      9'h002, 9'h000, 9'h000, 9'h1E9
   };

   biff8_string_to_utf8_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte         (req_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_byte         (rsp_byte),
      .rsp_consumed     (rsp_consumed),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_wdata        (csr_wdata)
   );

   biff8_utf8_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte         (req_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_byte         (rsp_byte),
      .rsp_consumed     (rsp_consumed),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .pending          (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_id != stall_seen) begin
         stall_seen <= stall_id;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic push_request(input logic [7:0] b, input logic l);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte <= b;
      req_last <= l;
      do @(posedge clock); while (!req_ready);
      phase_bytes++;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_count_width(input bit one);
      csr_write_enable <= 1'b1;
      csr_wdata <= one;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      count_one = one;
   endtask

   task automatic send_string();
      logic [7:0]  bytes_q[$];
      logic [15:0] count;
      logic [15:0] runs;
      logic [15:0] code;
      logic [31:0] ext;
      logic [7:0]  flags;
      longint      skip_total;
      int          nbuilt;
      int          cut;
      int          i;
      bit          broken;
      bit          complete;
      bit          end_mark;
      broken = ($urandom_range(0, 99) < 25);
      flags = 8'($urandom_range(0, 255));
      if (broken) begin
         count = 16'($urandom);
         runs = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
         ext = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 6));
      end else begin
         count = 16'($urandom_range(0, 5));
         runs = 16'($urandom_range(0, 2));
         ext = $urandom_range(0, 5);
      end
      if (count_one) count[15:8] = 8'h00;
      if (!flags[3]) runs = '0;
      if (!flags[2]) ext = '0;

      bytes_q.insert(bytes_q.size(), count[7:0]);
      if (!count_one) bytes_q.insert(bytes_q.size(), count[15:8]);
      bytes_q.insert(bytes_q.size(), flags);
      if (flags[3]) begin
         bytes_q.insert(bytes_q.size(), runs[7:0]);
         bytes_q.insert(bytes_q.size(), runs[15:8]);
      end
      if (flags[2]) begin
         for (i = 0; i < 4; i++) bytes_q.insert(bytes_q.size(), ext[8*i +: 8]);
      end
      nbuilt = (count > 6) ? 6 : int'(count);
      for (i = 0; i < nbuilt; i++) begin
         if (!flags[0]) begin
            bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 3))
               0: code = 16'($urandom_range(16'h0000, 16'h007F));
               1: code = 16'($urandom_range(16'h0080, 16'h07FF));
               2: code = 16'($urandom_range(16'h0800, 16'hFFFF));
               default: code = 16'($urandom);
            endcase
            bytes_q.insert(bytes_q.size(), code[7:0]);
            bytes_q.insert(bytes_q.size(), code[15:8]);
         end
      end
      skip_total = longint'(runs) * 4 + longint'(ext);
      for (i = 0; i < skip_total && i < 16; i++) begin
         bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
      end
      complete = (nbuilt == int'(count)) && (skip_total <= 16);

      if (broken || !complete) begin
         cut = int'($urandom_range(0, bytes_q.size() - 1));
         end_mark = 1'b1;
      end else begin
         cut = bytes_q.size() - 1;
         end_mark = ($urandom_range(0, 3) == 0);
      end
      for (i = 0; i <= cut; i++) push_request(bytes_q[i], (i == cut) && end_mark);
   endtask

   task automatic run_phase(input int setting, input bit one);
      bit paused;
      paused = 1'b0;
      case (setting)
         0: begin req_idle_pct <= 29; rsp_idle_pct <= 81; end
         1: begin req_idle_pct <= 81; rsp_idle_pct <= 29; end
         default: begin req_idle_pct <= 0; rsp_idle_pct <= 0; end
      endcase
      set_count_width(one);
      stall_id <= stall_id + 1;
      phase_bytes = 0;
      while (phase_bytes < 52) begin
         send_string();
         if (!paused && phase_bytes >= 26) begin
            drain_all();
            paused = 1'b1;
         end
      end
      drain_all();
   endtask

   initial begin
      int i;
      int setting;
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < 28; i++) push_request(directed_seq[i][7:0], directed_seq[i][8]);
      drain_all();

      for (setting = 0; setting < 3; setting++) begin
         for (k = 0; k < 2; k++) run_phase(setting, bit'(k) ^ ~setting[0]);
      end

      drain_all();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/biff8_pkg.sv
hw/rtl/biff8_parse.sv
hw/rtl/biff8_emit.sv
hw/rtl/biff8_string_to_utf8_core.sv
hw/rtl/biff8_checker.sv
bench/biff8_utf8_checker.sv
bench/testbench.sv
